// ===== design/crb_pkg.sv =====
// shared types, codes and constants for the catmull-rom to bezier stream core
// depends on nothing; every other file but crb_fifo refers to it by scoped names
`default_nettype none

package crb_pkg;

   // tension register
   localparam int TIGHT_WIDTH = 15;
   localparam logic [TIGHT_WIDTH-1:0] TIGHT_RESET = 15'd8192;

   // weights are in units of 1/(3 * 2^14); rounding adds half of that unit
   localparam int ROUND_SHIFT = 14;
   localparam int ROUND_BIAS  = 24576;

   // geometry of a job and of the queues
   localparam int NUM_COORDS   = 4;
   localparam int NUM_POINTS   = 4;
   localparam int JOB_DEPTH    = 2;
   localparam int OUT_DEPTH    = 8;
   localparam int LANE_LATENCY = 5;

   // what the front part hands to the back part for one accepted word
   localparam int JOB_MODE_WIDTH = 3;
   typedef enum logic [JOB_MODE_WIDTH-1:0] {
      JOB_ERR       = 3'd0,
      JOB_START     = 3'd1,
      JOB_START_END = 3'd2,
      JOB_INNER     = 3'd3,
      JOB_INNER_END = 3'd4
   } job_mode_type;

   typedef enum logic [1:0] {
      SEG_START = 2'd0,
      SEG_INNER = 2'd1,
      SEG_END   = 2'd2
   } seg_kind_type;

   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_SHORT = 1'b1;

   // point slots of a job: three window points and the current one
   localparam logic [1:0] PT0 = 2'd0;
   localparam logic [1:0] PT1 = 2'd1;
   localparam logic [1:0] PT2 = 2'd2;
   localparam logic [1:0] PT3 = 2'd3;

   // value = round((2^14 * (u + 2v) + t * (x - y)) / (3 * 2^14))
   typedef struct packed {
      logic [1:0] u;
      logic [1:0] v;
      logic [1:0] x;
      logic [1:0] y;
   } op_sel_type;

   typedef struct packed {
      logic [1:0]   point_index;
      seg_kind_type segment_kind;
      logic         run_end;
      logic         status;
   } rsp_meta_type;

   localparam int META_WIDTH = $bits(rsp_meta_type);

   typedef struct packed {
      logic [7:0] quot;
      logic [1:0] rem;
   } div3_type;

   // operand slots for each bezier point of each segment kind
   function automatic op_sel_type sel_ops(input seg_kind_type kind, input logic [1:0] idx);
      op_sel_type sel;
      sel = '{u: PT1, v: PT1, x: PT1, y: PT1};
      case (kind)
         SEG_START: begin
            case (idx)
               2'd0:    sel = '{u: PT1, v: PT1, x: PT1, y: PT1};
               2'd1:    sel = '{u: PT1, v: PT2, x: PT1, y: PT3};
               2'd2:    sel = '{u: PT2, v: PT2, x: PT1, y: PT3};
               default: sel = '{u: PT2, v: PT2, x: PT2, y: PT2};
            endcase
         end
         SEG_INNER: begin
            case (idx)
               2'd0:    sel = '{u: PT1, v: PT1, x: PT1, y: PT1};
               2'd1:    sel = '{u: PT1, v: PT1, x: PT2, y: PT0};
               2'd2:    sel = '{u: PT2, v: PT2, x: PT1, y: PT3};
               default: sel = '{u: PT2, v: PT2, x: PT2, y: PT2};
            endcase
         end
         SEG_END: begin
            case (idx)
               2'd0:    sel = '{u: PT2, v: PT2, x: PT2, y: PT2};
               2'd1:    sel = '{u: PT2, v: PT2, x: PT3, y: PT1};
               2'd2:    sel = '{u: PT3, v: PT2, x: PT3, y: PT1};
               default: sel = '{u: PT3, v: PT3, x: PT3, y: PT3};
            endcase
         end
         default: sel = '{u: PT1, v: PT1, x: PT1, y: PT1};
      endcase
      return sel;
   endfunction

   // one byte of long division by three; remainder in is at most two
   function automatic div3_type div3_byte(input logic [1:0] rem_in, input logic [7:0] digit);
      logic [9:0]  num;
      logic [19:0] scaled;
      logic [9:0]  back;
      div3_type    res;
      num      = {rem_in, digit};
      scaled   = 20'(num) * 20'd683;
      res.quot = scaled[18:11];
      back     = num - 10'(res.quot) * 10'd3;
      res.rem  = back[1:0];
      return res;
   endfunction

endpackage

`default_nettype wire

// ===== design/crb_fifo.sv =====
// small first-in first-out queue of packed words, head read straight from registers
// depends on nothing outside this file
`default_nettype none

module crb_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   // status and handshakes
   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;
   assign rdata   = mem_ff[rd_ptr_ff];

   // pointer and fill count next values
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CNT_W'(do_push) - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

`default_nettype wire

// ===== design/crb_front.sv =====
// front part: takes input words, keeps the three-point window and point count,
// and turns each word that closes a segment or ends a short curve into a back-part job; uses crb_pkg
`default_nettype none

module crb_front #(
   parameter int VW = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   output logic                 full,
   input  logic signed [VW-1:0] in_x,
   input  logic signed [VW-1:0] in_y,
   input  logic signed [VW-1:0] in_z,
   input  logic [VW-2:0]        in_radius,
   input  logic                 last_point,
   output logic                 job_push,
   output logic [crb_pkg::JOB_MODE_WIDTH+crb_pkg::NUM_POINTS*crb_pkg::NUM_COORDS*VW-1:0]
                                job_word,
   input  logic                 job_full
);

   localparam int PTW = crb_pkg::NUM_COORDS * VW;

   logic [VW-1:0]        win_ff [3][crb_pkg::NUM_COORDS];
   logic [VW-1:0]        win_in [3][crb_pkg::NUM_COORDS];
   logic [VW-1:0]        cur    [crb_pkg::NUM_COORDS];
   logic [1:0]           seen_ff, seen_in;
   logic                 accept;
   logic                 has_job;
   crb_pkg::job_mode_type mode;

   assign full   = job_full;
   assign accept = push & ~job_full;

   assign cur[0] = in_x;
   assign cur[1] = in_y;
   assign cur[2] = in_z;
   assign cur[3] = {1'b0, in_radius};

   // classify the word by how many points of this curve came before it
   always_comb begin
      has_job = 1'b0;
      mode    = crb_pkg::JOB_ERR;
      case (seen_ff)
         2'd2: begin
            has_job = 1'b1;
            mode    = last_point ? crb_pkg::JOB_START_END : crb_pkg::JOB_START;
         end
         2'd3: begin
            has_job = 1'b1;
            mode    = last_point ? crb_pkg::JOB_INNER_END : crb_pkg::JOB_INNER;
         end
         default: begin
            has_job = last_point;
            mode    = crb_pkg::JOB_ERR;
         end
      endcase
   end

   assign job_push = accept & has_job;

   // job word: window points in slots 0..2, current point in slot 3
   always_comb begin
      job_word = '0;
      job_word[$bits(job_word)-1 -: crb_pkg::JOB_MODE_WIDTH] = mode;
      for (int c = 0; c < crb_pkg::NUM_COORDS; c++) begin
         job_word[0 * PTW + c * VW +: VW] = win_ff[0][c];
         job_word[1 * PTW + c * VW +: VW] = win_ff[1][c];
         job_word[2 * PTW + c * VW +: VW] = win_ff[2][c];
         job_word[3 * PTW + c * VW +: VW] = cur[c];
      end
   end

   // window shift and point count
   always_comb begin
      for (int c = 0; c < crb_pkg::NUM_COORDS; c++) begin
         win_in[0][c] = win_ff[1][c];
         win_in[1][c] = win_ff[2][c];
         win_in[2][c] = cur[c];
      end
      if (last_point) begin
         seen_in = 2'd0;
      end else if (seen_ff == 2'd3) begin
         seen_in = 2'd3;
      end else begin
         seen_in = seen_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= 2'd0;
      end else if (accept) begin
         seen_ff <= seen_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         win_ff <= win_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/crb_lane.sv =====
// one coordinate lane: weighted sum, rounding, division by three, saturation
// five register stages, no stall; uses crb_pkg
`default_nettype none

module crb_lane #(
   parameter int VW = 32
) (
   input  logic                                  clock,
   input  logic [crb_pkg::TIGHT_WIDTH-1:0]       tight,
   input  logic signed [VW-1:0]                  op_u,
   input  logic signed [VW-1:0]                  op_v,
   input  logic signed [VW-1:0]                  op_x,
   input  logic signed [VW-1:0]                  op_y,
   output logic signed [VW-1:0]                  value
);

   localparam int SW  = VW + 2;
   localparam int DW  = VW + 1;
   localparam int PW  = VW + 17;
   localparam int MW  = ((VW + 4 + 7) / 8) * 8;
   localparam int NCH = MW / 8;
   localparam int NHI = (NCH + 1) / 2;
   localparam int NLO = NCH - NHI;
   localparam int HW  = NHI * 8;
   localparam int LW  = NLO * 8;

   // offset that makes the dividend non-negative, and its quotient removed again
   localparam logic [MW-1:0] DIV_OFFSET = MW'(3) << (VW + 2);
   localparam logic [MW-1:0] QUOT_BIAS  = MW'(1) << (VW + 2);
   localparam logic signed [MW-1:0] VMAX = {{(MW - VW + 1){1'b0}}, {(VW - 1){1'b1}}};
   localparam logic signed [MW-1:0] VMIN = {{(MW - VW + 1){1'b1}}, {(VW - 1){1'b0}}};

   logic signed [SW-1:0] s_ff, s_in, s2_ff;
   logic signed [DW-1:0] d_ff, d_in;
   logic signed [PW-1:0] t_ext, d_ext, prod_ff, prod_in;
   logic signed [PW-1:0] rsum, rsh;
   logic [MW-1:0]        m_ff, m_in;
   logic [HW-1:0]        qhi_ff, qhi_in;
   logic [LW-1:0]        lo_ff;
   logic [1:0]           rem_ff, rem_in;
   logic [LW-1:0]        qlo;
   logic [MW-1:0]        quot;
   logic signed [MW-1:0] fin;
   logic signed [VW-1:0] value_ff, value_in;

   // stage 1: base sum u + 2v and tension difference x - y
   assign s_in = SW'(op_u) + (SW'(op_v) <<< 1);
   assign d_in = DW'(op_x) - DW'(op_y);

   // stage 2: tension times difference
   assign t_ext   = $signed(PW'({1'b0, tight}));
   assign d_ext   = PW'(d_ff);
   assign prod_in = t_ext * d_ext;

   // stage 3: floor by 2^14 with half-unit bias, offset for unsigned division
   assign rsum = prod_ff + PW'(crb_pkg::ROUND_BIAS);
   assign rsh  = rsum >>> crb_pkg::ROUND_SHIFT;
   assign m_in = MW'(s2_ff) + MW'(rsh) + DIV_OFFSET;

   // stage 4: upper bytes of the division by three
   always_comb begin
      crb_pkg::div3_type step;
      logic [1:0]        rem;
      rem    = 2'd0;
      qhi_in = '0;
      for (int i = 0; i < NHI; i++) begin
         step = crb_pkg::div3_byte(rem, m_ff[MW - 1 - 8 * i -: 8]);
         qhi_in[HW - 1 - 8 * i -: 8] = step.quot;
         rem = step.rem;
      end
      rem_in = rem;
   end

   // stage 5: lower bytes, remove offset, saturate
   always_comb begin
      crb_pkg::div3_type step;
      logic [1:0]        rem;
      rem = rem_ff;
      qlo = '0;
      for (int i = 0; i < NLO; i++) begin
         step = crb_pkg::div3_byte(rem, lo_ff[LW - 1 - 8 * i -: 8]);
         qlo[LW - 1 - 8 * i -: 8] = step.quot;
         rem = step.rem;
      end
      quot = {qhi_ff, qlo};
      fin  = $signed(quot - QUOT_BIAS);
      if (fin > VMAX) begin
         value_in = VMAX[VW-1:0];
      end else if (fin < VMIN) begin
         value_in = VMIN[VW-1:0];
      end else begin
         value_in = fin[VW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      s_ff     <= s_in;
      d_ff     <= d_in;
      s2_ff    <= s_ff;
      prod_ff  <= prod_in;
      m_ff     <= m_in;
      qhi_ff   <= qhi_in;
      rem_ff   <= rem_in;
      lo_ff    <= m_ff[LW-1:0];
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

`default_nettype wire

// ===== design/crb_back.sv =====
// back part: walks each job one bezier point per cycle while the output queue
// has room, drives the four coordinate lanes and tracks that room; uses crb_pkg and crb_lane
`default_nettype none

module crb_back #(
   parameter int VW = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [crb_pkg::TIGHT_WIDTH-1:0]     tight,
   input  logic [crb_pkg::JOB_MODE_WIDTH+crb_pkg::NUM_POINTS*crb_pkg::NUM_COORDS*VW-1:0]
                                               job_word,
   input  logic                                job_empty,
   output logic                                job_pop,
   input  logic                                rsp_take,
   output logic                                out_push,
   output logic [crb_pkg::META_WIDTH+crb_pkg::NUM_COORDS*VW-1:0] out_word
);

   localparam int PTW   = crb_pkg::NUM_COORDS * VW;
   localparam int LAT   = crb_pkg::LANE_LATENCY;
   localparam int RES_W = $clog2(crb_pkg::OUT_DEPTH + 1);

   crb_pkg::job_mode_type mode;
   crb_pkg::seg_kind_type kind;
   crb_pkg::op_sel_type   sel;
   crb_pkg::rsp_meta_type meta;
   crb_pkg::rsp_meta_type meta_ff [LAT];
   logic                  vld_ff  [LAT];

   logic [2:0]            idx_ff, idx_in;
   logic [2:0]            last_idx;
   logic [RES_W-1:0]      reserved_ff, reserved_in;
   logic                  issue, job_done;

   logic signed [VW-1:0]  pts      [crb_pkg::NUM_POINTS][crb_pkg::NUM_COORDS];
   logic signed [VW-1:0]  u_op     [crb_pkg::NUM_COORDS];
   logic signed [VW-1:0]  v_op     [crb_pkg::NUM_COORDS];
   logic signed [VW-1:0]  x_op     [crb_pkg::NUM_COORDS];
   logic signed [VW-1:0]  y_op     [crb_pkg::NUM_COORDS];
   logic signed [VW-1:0]  lane_val [crb_pkg::NUM_COORDS];

   assign mode = crb_pkg::job_mode_type'(job_word[$bits(job_word)-1 -: crb_pkg::JOB_MODE_WIDTH]);

   // results per job: one error word, one segment or two segments
   always_comb begin
      case (mode)
         crb_pkg::JOB_ERR:       last_idx = 3'd0;
         crb_pkg::JOB_START:     last_idx = 3'd3;
         crb_pkg::JOB_INNER:     last_idx = 3'd3;
         crb_pkg::JOB_START_END: last_idx = 3'd7;
         crb_pkg::JOB_INNER_END: last_idx = 3'd7;
         default:                last_idx = 3'd0;
      endcase
   end

   // issue one point when a job waits and the output queue has room for it
   assign issue    = ~job_empty & (reserved_ff < RES_W'(crb_pkg::OUT_DEPTH));
   assign job_done = (idx_ff == last_idx);
   assign job_pop  = issue & job_done;

   always_comb begin
      idx_in = idx_ff;
      if (issue) begin
         idx_in = job_done ? 3'd0 : idx_ff + 3'd1;
      end
      reserved_in = reserved_ff + RES_W'(issue) - RES_W'(rsp_take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff      <= 3'd0;
         reserved_ff <= '0;
      end else begin
         idx_ff      <= idx_in;
         reserved_ff <= reserved_in;
      end
   end

   // segment kind and result tags of the point being issued
   always_comb begin
      if (idx_ff[2]) begin
         kind = crb_pkg::SEG_END;
      end else if (mode == crb_pkg::JOB_START || mode == crb_pkg::JOB_START_END) begin
         kind = crb_pkg::SEG_START;
      end else begin
         kind = crb_pkg::SEG_INNER;
      end
      if (mode == crb_pkg::JOB_ERR) begin
         meta.point_index  = 2'd0;
         meta.segment_kind = crb_pkg::SEG_START;
         meta.run_end      = 1'b1;
         meta.status       = crb_pkg::STATUS_SHORT;
      end else begin
         meta.point_index  = idx_ff[1:0];
         meta.segment_kind = kind;
         meta.run_end      = job_done;
         meta.status       = crb_pkg::STATUS_OK;
      end
   end

   assign sel = crb_pkg::sel_ops(kind, idx_ff[1:0]);

   // operand selection from the job's four point slots
   always_comb begin
      for (int k = 0; k < crb_pkg::NUM_POINTS; k++) begin
         for (int c = 0; c < crb_pkg::NUM_COORDS; c++) begin
            pts[k][c] = job_word[k * PTW + c * VW +: VW];
         end
      end
      for (int c = 0; c < crb_pkg::NUM_COORDS; c++) begin
         u_op[c] = pts[sel.u][c];
         v_op[c] = pts[sel.v][c];
         x_op[c] = pts[sel.x][c];
         y_op[c] = pts[sel.y][c];
      end
   end

   // coordinate lanes: x, y, z, radius
   for (genvar c = 0; c < crb_pkg::NUM_COORDS; c++) begin : g_lane
      crb_lane #(
         .VW (VW)
      ) u_lane (
         .clock (clock),
         .tight (tight),
         .op_u  (u_op[c]),
         .op_v  (v_op[c]),
         .op_x  (x_op[c]),
         .op_y  (y_op[c]),
         .value (lane_val[c])
      );
   end

   // valid and tags travel beside the lanes
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LAT; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else begin
         vld_ff[0] <= issue;
         for (int i = 1; i < LAT; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      meta_ff[0] <= meta;
      for (int i = 1; i < LAT; i++) begin
         meta_ff[i] <= meta_ff[i-1];
      end
   end

   // result word; the short-curve word carries zero values
   assign out_push = vld_ff[LAT-1];

   always_comb begin
      out_word = '0;
      out_word[$bits(out_word)-1 -: crb_pkg::META_WIDTH] = meta_ff[LAT-1];
      for (int c = 0; c < crb_pkg::NUM_COORDS; c++) begin
         if (meta_ff[LAT-1].status == crb_pkg::STATUS_SHORT) begin
            out_word[c * VW +: VW] = '0;
         end else begin
            out_word[c * VW +: VW] = lane_val[c];
         end
      end
   end

endmodule

`default_nettype wire

// ===== design/catmull_rom_to_bezier_stream_core.sv =====
// top level of the catmull-rom to bezier stream core: tension register,
// front part, job queue, back part and result queue; uses crb_pkg and all crb_ modules
`default_nettype none

// Converts a stream of catmull-rom control points (x, y, z, radius, last-point
// flag) into cubic bezier control points, four per segment, with values in
// signed Q16.16 rounded to nearest and saturated. The third point of a curve
// yields the start segment, each later point the inner segment, and the last
// point also the end segment; a curve of fewer than three points yields one
// word with status set. A point that closes no segment yields no bezier
// point; a segment yields four, so an inner point yields four bezier points
// and a point that also ends the curve yields eight. The back part's
// sequencer issues one bezier point (all four coordinates in parallel lanes)
// per cycle while a job waits and the result queue has room. Each result
// passes through the lane registers and then the result queue. The
// tension register is written through the csr channel, which is always ready,
// and is to be written only while no words are in flight.
module catmull_rom_to_bezier_stream_core #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   // input points
   input  logic                                push,
   output logic                                full,
   input  logic signed [VALUE_WIDTH-1:0]       req_in_x,
   input  logic signed [VALUE_WIDTH-1:0]       req_in_y,
   input  logic signed [VALUE_WIDTH-1:0]       req_in_z,
   input  logic [VALUE_WIDTH-2:0]              req_in_radius,
   input  logic                                req_last_point,
   // bezier points
   output logic                                empty,
   input  logic                                pop,
   output logic signed [VALUE_WIDTH-1:0]       rsp_out_x,
   output logic signed [VALUE_WIDTH-1:0]       rsp_out_y,
   output logic signed [VALUE_WIDTH-1:0]       rsp_out_z,
   output logic signed [VALUE_WIDTH-1:0]       rsp_out_radius,
   output logic [1:0]                          rsp_point_index,
   output logic [1:0]                          rsp_segment_kind,
   output logic                                rsp_run_end,
   output logic                                rsp_status,
   // tension register
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [crb_pkg::TIGHT_WIDTH-1:0]     csr_tightness
);

   localparam int VW        = VALUE_WIDTH;
   localparam int JOB_WIDTH = crb_pkg::JOB_MODE_WIDTH
                              + crb_pkg::NUM_POINTS * crb_pkg::NUM_COORDS * VW;
   localparam int OUT_WIDTH = crb_pkg::META_WIDTH + crb_pkg::NUM_COORDS * VW;

   logic [crb_pkg::TIGHT_WIDTH-1:0] tight_ff;
   logic                            job_push, job_full, job_pop, job_empty;
   logic [JOB_WIDTH-1:0]            job_wdata, job_rdata;
   logic                            out_push;
   logic [OUT_WIDTH-1:0]            out_wdata, out_rdata;
   logic                            rsp_take;
   crb_pkg::rsp_meta_type           head_meta;

   // tension register
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         tight_ff <= crb_pkg::TIGHT_RESET;
      end else if (csr_valid) begin
         tight_ff <= csr_tightness;
      end
   end

   // front part
   crb_front #(
      .VW (VW)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .full       (full),
      .in_x       (req_in_x),
      .in_y       (req_in_y),
      .in_z       (req_in_z),
      .in_radius  (req_in_radius),
      .last_point (req_last_point),
      .job_push   (job_push),
      .job_word   (job_wdata),
      .job_full   (job_full)
   );

   // job queue between the two parts
   crb_fifo #(
      .WIDTH (JOB_WIDTH),
      .DEPTH (crb_pkg::JOB_DEPTH)
   ) u_job_fifo (
      .clock (clock),
      .reset (reset),
      .push  (job_push),
      .wdata (job_wdata),
      .full  (job_full),
      .pop   (job_pop),
      .rdata (job_rdata),
      .empty (job_empty)
   );

   // back part
   crb_back #(
      .VW (VW)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .tight     (tight_ff),
      .job_word  (job_rdata),
      .job_empty (job_empty),
      .job_pop   (job_pop),
      .rsp_take  (rsp_take),
      .out_push  (out_push),
      .out_word  (out_wdata)
   );

   // result queue; the back part never pushes beyond its room
   assign rsp_take = pop & ~empty;

   crb_fifo #(
      .WIDTH (OUT_WIDTH),
      .DEPTH (crb_pkg::OUT_DEPTH)
   ) u_out_fifo (
      .clock (clock),
      .reset (reset),
      .push  (out_push),
      .wdata (out_wdata),
      .full  (),
      .pop   (pop),
      .rdata (out_rdata),
      .empty (empty)
   );

   // result ports from the queue head
   assign head_meta        = crb_pkg::rsp_meta_type'(out_rdata[OUT_WIDTH-1 -: crb_pkg::META_WIDTH]);
   assign rsp_out_x        = out_rdata[0 * VW +: VW];
   assign rsp_out_y        = out_rdata[1 * VW +: VW];
   assign rsp_out_z        = out_rdata[2 * VW +: VW];
   assign rsp_out_radius   = out_rdata[3 * VW +: VW];
   assign rsp_point_index  = head_meta.point_index;
   assign rsp_segment_kind = head_meta.segment_kind;
   assign rsp_run_end      = head_meta.run_end;
   assign rsp_status       = head_meta.status;

endmodule

`default_nettype wire
